@@ rtl/core/glf_pkg.sv @@
// Shared constants and types for the greedy line folder.
// Used by the output queue and the top level; depends on nothing else.
`default_nettype none

package glf_pkg;

	// Characters per output line before a fold.
	localparam int LINE_WIDTH = 32;

	// Line store address width; the store is a ring of 2**STORE_AW entries.
	localparam int STORE_AW = (LINE_WIDTH > 1) ? $clog2(LINE_WIDTH) : 1;

	// Width of a character count that can hold LINE_WIDTH itself.
	localparam int CNT_W = $clog2(LINE_WIDTH + 1);

	localparam logic [7:0] CH_SPACE   = 8'd32;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_NEWLINE = 8'd10;

	// One result on its way to the output channel.
	typedef struct packed {
		logic [7:0] char_out;
		logic       last_of_run;
	} out_item_t;

endpackage

`default_nettype wire

@@ rtl/core/glf_outq.sv @@
// Two-entry output queue of the greedy line folder; the head entry drives the port.
// Depends on glf_pkg for the result item type.
`default_nettype none

module glf_outq import glf_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire out_item_t push_item,
	input  wire logic      pop,
	output logic [1:0]     count,
	output out_item_t      head_item
);

	logic [1:0] count_q;
	logic [1:0] count_d;
	out_item_t  head_q;
	out_item_t  skid_q;
	out_item_t  head_d;
	out_item_t  skid_d;

	always_comb begin
		count_d = count_q;
		head_d  = head_q;
		skid_d  = skid_q;
		case (count_q)
			2'd0: begin
				if (push) begin
					head_d  = push_item;
					count_d = 2'd1;
				end
			end
			2'd1: begin
				if (push && pop) begin
					head_d = push_item;
				end else if (push) begin
					skid_d  = push_item;
					count_d = 2'd2;
				end else if (pop) begin
					count_d = 2'd0;
				end
			end
			2'd2: begin
				if (pop) begin
					head_d = skid_q;
					if (push) begin
						skid_d = push_item;
					end else begin
						count_d = 2'd1;
					end
				end
			end
			default: begin
				count_d = 2'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		head_q <= head_d;
		skid_q <= skid_d;
	end

	assign count     = count_q;
	assign head_item = head_q;

endmodule

`default_nettype wire

@@ rtl/core/greedy_line_folder_top.sv @@
// Top level of the greedy word-wrap line folder: ring line store, fold control, emit sequencer.
// Depends on glf_pkg and instantiates glf_outq.
//
// Usage:
//   The slave stream takes one transaction per input item: s_axis_tdata carries a character
//   byte and s_axis_tuser marks end of stream. Ordinary characters go into a ring-shaped line
//   store and are taken while no line is being emitted. When the line reaches LINE_WIDTH characters, the text up to
//   and including the last space or tab (or the whole line when there is none) is emitted,
//   followed by a newline; the remainder stays in place and the ring head simply moves past
//   the emitted part, so nothing is copied. A newline input, or end of stream with buffered
//   text, emits the buffer and one newline. End of stream on an empty buffer emits nothing.
//   The master stream carries one transaction per result: m_axis_tdata is the byte and
//   m_axis_tlast marks the final result caused by one input item.
//   Throughput: while emitting, one result leaves per cycle when the receiver is ready; the
//   single read port of the line store sets that pace. An item that emits anything keeps
//   the input closed until the sequencer has issued its newline; the first result
//   passes through the store read register and then the output queue register.
//   When the receiver stalls, reads stop as soon as the two-entry output queue and the read
//   in flight would fill it, and resume without losing or repeating a byte.
//   Reset clears the fill count, blank tracking, ring head and sequencer; the store contents
//   are left as they are and are only read after being written.
`default_nettype none

module greedy_line_folder_top import glf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] char_in
	input  wire logic       s_axis_tuser,  // [0] end_of_stream
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] char_out
	output logic            m_axis_tlast
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_NL
	} state_t;

	state_t              state_q;
	logic [STORE_AW-1:0] head_q;
	logic [CNT_W-1:0]    fill_q;
	logic                seen_q;
	logic [STORE_AW-1:0] bidx_q;
	logic [STORE_AW-1:0] rd_ptr_q;
	logic [CNT_W-1:0]    rd_left_q;
	logic                pend_s1;
	logic                pend_nl_s1;
	logic [7:0]          rd_data_s1;

	logic [7:0] store_mem [2**STORE_AW];

	logic                in_acc;
	logic                is_nl_in;
	logic                is_char;
	logic                is_flush;
	logic                is_blank;
	logic [STORE_AW-1:0] wr_addr;
	logic [CNT_W-1:0]    fill_inc;
	logic                line_full;
	logic                seen_new;
	logic [STORE_AW-1:0] bidx_new;
	logic [CNT_W-1:0]    keep_cnt;
	logic [CNT_W-1:0]    fold_cnt;
	logic                q_pop;
	logic [1:0]          q_count;
	logic [2:0]          q_occ;
	logic                issue;
	out_item_t           push_item;
	out_item_t           head_item;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign is_nl_in      = !s_axis_tuser && (s_axis_tdata == CH_NEWLINE);
	assign is_char       = !s_axis_tuser && !is_nl_in;
	assign is_flush      = is_nl_in || (s_axis_tuser && (fill_q != '0));
	assign is_blank      = (s_axis_tdata == CH_SPACE) || (s_axis_tdata == CH_TAB);

	// The ring wraps at 2**STORE_AW, which is never less than the line width.
	assign wr_addr   = head_q + fill_q[STORE_AW-1:0];
	assign fill_inc  = fill_q + CNT_W'(1);
	assign line_full = (fill_inc == CNT_W'(LINE_WIDTH));
	assign seen_new  = seen_q || is_blank;
	assign bidx_new  = is_blank ? fill_q[STORE_AW-1:0] : bidx_q;
	assign keep_cnt  = CNT_W'(LINE_WIDTH - 1) - CNT_W'(bidx_new);
	assign fold_cnt  = seen_new ? (CNT_W'(bidx_new) + CNT_W'(1)) : CNT_W'(LINE_WIDTH);

	// A read may start when the queue, counting the read in flight and this cycle's
	// departure, still has a free entry for its data.
	assign q_pop = m_axis_tvalid && m_axis_tready;
	assign q_occ = 3'(q_count) + 3'(pend_s1) - 3'(q_pop);
	assign issue = (q_occ < 3'd2) && ((state_q == ST_EMIT) || (state_q == ST_NL));

	always_ff @(posedge clk) begin
		if (in_acc && is_char) begin
			store_mem[wr_addr] <= s_axis_tdata;
		end
		rd_data_s1 <= store_mem[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			fill_q     <= '0;
			seen_q     <= 1'b0;
			bidx_q     <= '0;
			rd_ptr_q   <= '0;
			rd_left_q  <= '0;
			pend_s1    <= 1'b0;
			pend_nl_s1 <= 1'b0;
		end else begin
			pend_s1    <= issue;
			pend_nl_s1 <= (state_q == ST_NL);
			case (state_q)
				ST_IDLE: begin
					if (in_acc && is_char) begin
						if (line_full) begin
							// Fold: emit through the last blank, keep the rest in place.
							rd_ptr_q  <= head_q;
							rd_left_q <= fold_cnt;
							head_q    <= seen_new ? (head_q + bidx_new + STORE_AW'(1)) : head_q;
							fill_q    <= seen_new ? keep_cnt : '0;
							seen_q    <= 1'b0;
							bidx_q    <= '0;
							state_q   <= ST_EMIT;
						end else begin
							fill_q <= fill_inc;
							seen_q <= seen_new;
							bidx_q <= bidx_new;
						end
					end else if (in_acc && is_flush) begin
						rd_ptr_q  <= head_q;
						rd_left_q <= fill_q;
						fill_q    <= '0;
						seen_q    <= 1'b0;
						bidx_q    <= '0;
						state_q   <= (fill_q != '0) ? ST_EMIT : ST_NL;
					end
				end
				ST_EMIT: begin
					if (issue) begin
						rd_ptr_q  <= rd_ptr_q + STORE_AW'(1);
						rd_left_q <= rd_left_q - CNT_W'(1);
						if (rd_left_q == CNT_W'(1)) begin
							state_q <= ST_NL;
						end
					end
				end
				ST_NL: begin
					if (issue) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The newline is the last result of every run that emits anything.
	assign push_item.char_out    = pend_nl_s1 ? CH_NEWLINE : rd_data_s1;
	assign push_item.last_of_run = pend_nl_s1;

	glf_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (pend_s1),
		.push_item (push_item),
		.pop       (q_pop),
		.count     (q_count),
		.head_item (head_item)
	);

	assign m_axis_tvalid = (q_count != 2'd0);
	assign m_axis_tdata  = head_item.char_out;
	assign m_axis_tlast  = head_item.last_of_run;

	a_fill_below_width: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < CNT_W'(LINE_WIDTH))
		else $error("line store fill count reached the line width");

	a_blank_inside_line: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> (CNT_W'(bidx_q) < fill_q))
		else $error("remembered blank lies outside the buffered text");

	a_emit_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (rd_left_q != '0))
		else $error("emit sequencer running with nothing left to read");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> ((q_count != 2'd2) || q_pop))
		else $error("store read data arrived with the output queue full");

endmodule

`default_nettype wire
